/* rtl/core/drm_pkg.sv */
// ----------------------------------------------------------------------------
// drm_pkg: descriptor ring manager definitions
// Command and result codes, field widths and descriptor bit positions.
// ----------------------------------------------------------------------------
package drm_pkg;

	localparam int LEN_W   = 14;
	localparam int SLOT_W  = 7;
	localparam int STAT_W  = 32;
	localparam int LWORD_W = 16;
	localparam int CODE_W  = 3;

	typedef enum logic [1:0] {
		CMD_TX_SUBMIT  = 2'd0,
		CMD_TX_RELEASE = 2'd1,
		CMD_RX_WRITTEN = 2'd2,
		CMD_RX_TAKE    = 2'd3
	} cmd_t;

	typedef enum logic [CODE_W-1:0] {
		RC_OK        = 3'd0,
		RC_BAD_ARG   = 3'd1,
		RC_LINK_DOWN = 3'd2,
		RC_RING_FULL = 3'd3,
		RC_RX_EMPTY  = 3'd4,
		RC_FRAME_ERR = 3'd5
	} rc_t;

	// transmit descriptor status bits
	localparam int TX_OWN_BIT   = 31;
	localparam int TX_LAST_BIT  = 29;
	localparam int TX_FIRST_BIT = 28;
	localparam int TX_EOR_BIT   = 21;
	// transmit length field
	localparam int TX_LEN_MSB   = 12;
	// receive descriptor status bits
	localparam int RX_OWN_BIT   = 31;
	localparam int RX_LEN_MSB   = 29;
	localparam int RX_LEN_LSB   = 16;
	localparam int RX_ERR_BIT   = 15;
	localparam int RX_FIRST_BIT = 9;
	localparam int RX_LAST_BIT  = 8;
	// receive length word end-of-ring bit
	localparam int RX_EOR_BIT   = 15;
	localparam logic [LEN_W-1:0] FCS_BYTES = 14'd4;

endpackage

/* rtl/core/drm_rx_store.sv */
// ----------------------------------------------------------------------------
// drm_rx_store: receive status word memory
// One write and one read port, registered read data. A read issued in the
// same cycle as a write to the same entry returns the new word.
// ----------------------------------------------------------------------------
module drm_rx_store #(
	parameter int DEPTH = 128,
	parameter int ADDR_W = 7
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [ADDR_W-1:0]          wr_addr,
	input  logic [drm_pkg::STAT_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [ADDR_W-1:0]          rd_addr,
	output logic [drm_pkg::STAT_W-1:0] rd_data
);
	import drm_pkg::*;

	logic [STAT_W-1:0] mem [DEPTH];
	logic [STAT_W-1:0] rd_q;
	logic [STAT_W-1:0] fwd_data_q;
	logic              fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			fwd_q      <= wr_en && (wr_addr == rd_addr);
			fwd_data_q <= wr_data;
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : rd_q;

endmodule

/* rtl/core/dma_descriptor_ring_manager.sv */
// ----------------------------------------------------------------------------
// dma_descriptor_ring_manager: transmit and receive descriptor rings
// Ownership tracking, submit/take checks and descriptor word generation.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel (in_valid/in_ready) carries one command word per cycle:
//   transmit submit, transmit release by DMA, receive status written by DMA,
//   or receive take. Every command returns exactly one result word on the
//   out_valid/out_ready channel, in order.
//   Config channel (cfg_valid/cfg_ready) writes ring_enabled; always ready,
//   write only while the command path is idle.
//   Pipeline: the input register loads at acceptance and the result register
//   loads from it when the output is not stalled. Throughput: one command per
//   cycle while out_ready is high; the ring indices and ownership bits are
//   updated in the single processing stage and the receive status memory is
//   read when the command is accepted, so back-to-back commands see each
//   other's effects.
//   Reset: ring disabled, all transmit slots host owned, all receive slots
//   DMA owned, both ring indices zero. The status memory is not cleared.
//   Stall: when out_ready is low the result register holds, the input
//   register fills, and in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module dma_descriptor_ring_manager #(
	parameter int RING_ENTRIES = 128,
	parameter int BUFFER_BYTES = 2048
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  drm_pkg::cmd_t               command,
	input  logic [drm_pkg::LEN_W-1:0]   length_value,
	input  logic                        link_up,
	input  logic [drm_pkg::SLOT_W-1:0]  slot_index,
	input  logic [drm_pkg::STAT_W-1:0]  receive_status,
	output logic                        out_valid,
	input  logic                        out_ready,
	output drm_pkg::rc_t                result_code,
	output logic [drm_pkg::SLOT_W-1:0]  used_slot,
	output logic [drm_pkg::STAT_W-1:0]  descriptor_status_word,
	output logic [drm_pkg::LWORD_W-1:0] descriptor_length_word,
	output logic [drm_pkg::LEN_W-1:0]   delivered_length
);
	import drm_pkg::*;

	localparam int IDX_W = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;
	localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
	localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(RING_ENTRIES - 1);
	localparam logic [LEN_W-1:0]   BUF_LEN  = LEN_W'(BUFFER_BYTES);
	localparam logic [LWORD_W-1:0] BUF_WORD = LWORD_W'(BUFFER_BYTES);

	// config
	logic ring_enabled_q;

	// input register
	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [LEN_W-1:0]  len_s1;
	logic              link_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [STAT_W-1:0] rstat_s1;

	// ring state
	logic [RING_ENTRIES-1:0] tx_own_q, tx_own_d;
	logic [RING_ENTRIES-1:0] rx_own_q, rx_own_d;
	logic [IDX_W-1:0]        tx_next_q, tx_next_d;
	logic [IDX_W-1:0]        rx_next_q, rx_next_d;

	// result register
	logic               out_valid_q;
	rc_t                code_q, code_d;
	logic [SLOT_W-1:0]  used_q, used_d;
	logic [STAT_W-1:0]  sword_q, sword_d;
	logic [LWORD_W-1:0] lword_q, lword_d;
	logic [LEN_W-1:0]   deliv_q, deliv_d;

	logic              in_acc;
	logic              adv_s1;
	logic              mem_we;
	logic [STAT_W-1:0] rx_stat;
	logic [IDX_W-1:0]  rd_addr;
	logic [EXT_W-1:0]  slot_ext;
	logic [IDX_W-1:0]  slot_idx;
	logic              slot_ok;
	logic [EXT_W-1:0]  tx_ext;
	logic [EXT_W-1:0]  rx_ext;
	logic              frame_ok;
	logic [LEN_W-1:0]  plen;
	logic [LEN_W-1:0]  stripped;

	assign cfg_ready = 1'b1;
	assign adv_s1    = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv_s1;
	assign in_acc    = in_valid && in_ready;

	assign slot_ext = EXT_W'(slot_s1);
	assign slot_idx = slot_ext[IDX_W-1:0];
	assign slot_ok  = int'(slot_s1) < RING_ENTRIES;
	assign tx_ext   = EXT_W'(tx_next_q);
	assign rx_ext   = EXT_W'(rx_next_q);

	assign frame_ok = !rx_stat[RX_ERR_BIT] && rx_stat[RX_FIRST_BIT] && rx_stat[RX_LAST_BIT];
	assign plen     = rx_stat[RX_LEN_MSB:RX_LEN_LSB];
	assign stripped = (plen >= FCS_BYTES) ? plen - FCS_BYTES : '0;

	always_comb begin
		tx_own_d  = tx_own_q;
		rx_own_d  = rx_own_q;
		tx_next_d = tx_next_q;
		rx_next_d = rx_next_q;
		mem_we    = 1'b0;
		code_d    = RC_OK;
		used_d    = '0;
		sword_d   = '0;
		lword_d   = '0;
		deliv_d   = '0;
		unique case (cmd_s1)
			CMD_TX_SUBMIT: begin
				used_d = tx_ext[SLOT_W-1:0];
				if (!ring_enabled_q || len_s1 == '0 || len_s1 > BUF_LEN) begin
					code_d = RC_BAD_ARG;
				end else if (!link_s1) begin
					code_d = RC_LINK_DOWN;
				end else if (tx_own_q[tx_next_q]) begin
					code_d = RC_RING_FULL;
				end else begin
					sword_d[TX_OWN_BIT]   = 1'b1;
					sword_d[TX_FIRST_BIT] = 1'b1;
					sword_d[TX_LAST_BIT]  = 1'b1;
					sword_d[TX_EOR_BIT]   = (tx_next_q == LAST_IDX);
					lword_d = LWORD_W'(len_s1[TX_LEN_MSB:0]);
					tx_own_d[tx_next_q] = 1'b1;
					tx_next_d = (tx_next_q == LAST_IDX) ? '0 : tx_next_q + 1'b1;
				end
			end
			CMD_TX_RELEASE: begin
				used_d = slot_s1;
				if (slot_ok) begin
					tx_own_d[slot_idx] = 1'b0;
				end
			end
			CMD_RX_WRITTEN: begin
				used_d = slot_s1;
				if (slot_ok) begin
					mem_we = 1'b1;
					rx_own_d[slot_idx] = rstat_s1[RX_OWN_BIT];
				end
			end
			CMD_RX_TAKE: begin
				used_d = rx_ext[SLOT_W-1:0];
				if (!ring_enabled_q) begin
					code_d = RC_BAD_ARG;
				end else if (rx_own_q[rx_next_q]) begin
					code_d = RC_RX_EMPTY;
				end else begin
					if (frame_ok) begin
						deliv_d = (stripped > len_s1) ? len_s1 : stripped;
					end
					code_d  = frame_ok ? RC_OK : RC_FRAME_ERR;
					lword_d = BUF_WORD;
					lword_d[RX_EOR_BIT] = lword_d[RX_EOR_BIT] | (rx_next_q == LAST_IDX);
					rx_own_d[rx_next_q] = 1'b1;
					rx_next_d = (rx_next_q == LAST_IDX) ? '0 : rx_next_q + 1'b1;
				end
			end
			default: begin
				code_d = RC_OK;
			end
		endcase
	end

	assign rd_addr = adv_s1 ? rx_next_d : rx_next_q;

	drm_rx_store #(
		.DEPTH  (RING_ENTRIES),
		.ADDR_W (IDX_W)
	) u_rx_store (
		.clk     (clk),
		.wr_en   (adv_s1 && mem_we),
		.wr_addr (slot_idx),
		.wr_data (rstat_s1),
		.rd_en   (in_acc),
		.rd_addr (rd_addr),
		.rd_data (rx_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_enabled_q <= 1'b0;
			valid_s1       <= 1'b0;
			out_valid_q    <= 1'b0;
			tx_own_q       <= '0;
			rx_own_q       <= '1;
			tx_next_q      <= '0;
			rx_next_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				ring_enabled_q <= cfg_data;
			end
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
				tx_own_q    <= tx_own_d;
				rx_own_q    <= rx_own_d;
				tx_next_q   <= tx_next_d;
				rx_next_q   <= rx_next_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1   <= command;
			len_s1   <= length_value;
			link_s1  <= link_up;
			slot_s1  <= slot_index;
			rstat_s1 <= receive_status;
		end
		if (adv_s1) begin
			code_q  <= code_d;
			used_q  <= used_d;
			sword_q <= sword_d;
			lword_q <= lword_d;
			deliv_q <= deliv_d;
		end
	end

	assign out_valid              = out_valid_q;
	assign result_code            = code_q;
	assign used_slot              = used_q;
	assign descriptor_status_word = sword_q;
	assign descriptor_length_word = lword_q;
	assign delivered_length       = deliv_q;

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: descriptor ring manager testbench
// Runs directed and random ring commands against a behavioral copy of both
// rings. Each result word is checked field by field, in order, while both
// handshakes idle at random outside one quiet window.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
	import drm_pkg::*;

	localparam int RING_ENTRIES = 128;
	localparam int BUFFER_BYTES = 2048;
	localparam int CYCLE_LIMIT  = 300000;

	typedef struct packed {
		cmd_t               command;
		logic [LEN_W-1:0]   length_value;
		logic               link_up;
		logic [SLOT_W-1:0]  slot_index;
		logic [STAT_W-1:0]  receive_status;
	} ring_cmd_t;

	typedef struct packed {
		rc_t                code;
		logic [SLOT_W-1:0]  slot;
		logic [STAT_W-1:0]  sword;
		logic [LWORD_W-1:0] lword;
		logic [LEN_W-1:0]   delivered;
	} ring_result_t;

	typedef enum {MODE_RX, MODE_FILL, MODE_NOISE, MODE_MIX} gen_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	cmd_t command = CMD_TX_SUBMIT;
	logic [LEN_W-1:0] length_value = '0;
	logic link_up = 1'b0;
	logic [SLOT_W-1:0] slot_index = '0;
	logic [STAT_W-1:0] receive_status = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rc_t result_code;
	logic [SLOT_W-1:0] used_slot;
	logic [STAT_W-1:0] descriptor_status_word;
	logic [LWORD_W-1:0] descriptor_length_word;
	logic [LEN_W-1:0] delivered_length;

	dma_descriptor_ring_manager #(
		.RING_ENTRIES(RING_ENTRIES),
		.BUFFER_BYTES(BUFFER_BYTES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.length_value(length_value),
		.link_up(link_up),
		.slot_index(slot_index),
		.receive_status(receive_status),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_code(result_code),
		.used_slot(used_slot),
		.descriptor_status_word(descriptor_status_word),
		.descriptor_length_word(descriptor_length_word),
		.delivered_length(delivered_length)
	);

	// ring shadow
	logic ring_en = 1'b0;
	logic tx_owned [RING_ENTRIES];
	logic rx_owned [RING_ENTRIES];
	logic [STAT_W-1:0] rx_status_mem [RING_ENTRIES];
	logic [SLOT_W-1:0] tx_head = '0;
	logic [SLOT_W-1:0] rx_head = '0;

	ring_cmd_t cmd_backlog [$];
	ring_result_t due_results [$];
	ring_cmd_t drv_word;
	int queued_cnt = 0;
	int accepted_cnt = 0;
	int err_count = 0;
	int cycle_cnt = 0;
	bit in_took = 1'b0;
	bit cfg_took = 1'b0;
	bit quiet;

	// stimulus-side ring tracking
	logic [SLOT_W-1:0] tx_rel = '0;
	logic [SLOT_W-1:0] rx_wr = '0;
	int tx_out = 0;

	initial begin
		for (int j = 0; j < RING_ENTRIES; j++) begin
			tx_owned[j] = 1'b0;
			rx_owned[j] = 1'b1;
			rx_status_mem[j] = '0;
		end
	end

	initial begin
		forever #6 clk = ~clk;
	end

	assign quiet = (cycle_cnt >= 400) && (cycle_cnt < 900);

	function automatic logic [SLOT_W-1:0] next_slot(logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(RING_ENTRIES - 1)) ? '0 : s + 1'b1;
	endfunction

	function automatic ring_result_t predict_ring(ring_cmd_t c);
		ring_result_t r;
		logic [STAT_W-1:0] st;
		logic [LEN_W-1:0] plen;
		logic ok;
		r = '0;
		r.code = RC_OK;
		case (c.command)
			CMD_TX_SUBMIT: begin
				r.slot = tx_head;
				if (!ring_en || c.length_value == 0 || c.length_value > BUFFER_BYTES)
					r.code = RC_BAD_ARG;
				else if (!c.link_up)
					r.code = RC_LINK_DOWN;
				else if (tx_owned[tx_head])
					r.code = RC_RING_FULL;
				else begin
					r.sword[TX_OWN_BIT] = 1'b1;
					r.sword[TX_FIRST_BIT] = 1'b1;
					r.sword[TX_LAST_BIT] = 1'b1;
					r.sword[TX_EOR_BIT] = (tx_head == SLOT_W'(RING_ENTRIES - 1));
					r.lword[TX_LEN_MSB:0] = c.length_value[TX_LEN_MSB:0];
					tx_owned[tx_head] = 1'b1;
					tx_head = next_slot(tx_head);
				end
			end
			CMD_TX_RELEASE: begin
				r.slot = c.slot_index;
				tx_owned[c.slot_index] = 1'b0;
			end
			CMD_RX_WRITTEN: begin
				r.slot = c.slot_index;
				rx_status_mem[c.slot_index] = c.receive_status;
				rx_owned[c.slot_index] = c.receive_status[RX_OWN_BIT];
			end
			default: begin
				r.slot = rx_head;
				if (!ring_en)
					r.code = RC_BAD_ARG;
				else if (rx_owned[rx_head])
					r.code = RC_RX_EMPTY;
				else begin
					st = rx_status_mem[rx_head];
					plen = st[RX_LEN_MSB:RX_LEN_LSB];
					ok = !st[RX_ERR_BIT] && st[RX_FIRST_BIT] && st[RX_LAST_BIT];
					if (!ok)
						plen = '0;
					else if (plen >= FCS_BYTES)
						plen = plen - FCS_BYTES;
					else
						plen = '0;
					if (plen > c.length_value)
						plen = c.length_value;
					r.delivered = plen;
					r.lword = LWORD_W'(BUFFER_BYTES);
					r.lword[RX_EOR_BIT] = (rx_head == SLOT_W'(RING_ENTRIES - 1));
					rx_owned[rx_head] = 1'b1;
					rx_head = next_slot(rx_head);
					r.code = ok ? RC_OK : RC_FRAME_ERR;
				end
			end
		endcase
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want) begin
			$display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
				cycle_cnt, name, got, want);
			err_count++;
		end
	endtask

	// driver
	always @(negedge clk) begin
		if (!in_valid || in_took) begin
			if (arst_n && cmd_backlog.size() != 0 && (quiet || $urandom_range(99) >= 15)) begin
				drv_word = cmd_backlog.pop_front();
				command <= drv_word.command;
				length_value <= drv_word.length_value;
				link_up <= drv_word.link_up;
				slot_index <= drv_word.slot_index;
				receive_status <= drv_word.receive_status;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		out_ready <= quiet || ($urandom_range(99) >= 15);
	end

	// monitor
	always @(posedge clk) begin
		ring_result_t got;
		ring_result_t want;
		ring_cmd_t seen;
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("CHECKS FAILED");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			got.code = result_code;
			got.slot = used_slot;
			got.sword = descriptor_status_word;
			got.lword = descriptor_length_word;
			got.delivered = delivered_length;
			if (due_results.size() == 0) begin
				check_field("unexpected result word", 32'(got.slot), 32'hffff_ffff);
			end else begin
				want = due_results.pop_front();
				check_field("result_code", 32'(got.code), 32'(want.code));
				check_field("used_slot", 32'(got.slot), 32'(want.slot));
				check_field("descriptor_status_word", got.sword, want.sword);
				check_field("descriptor_length_word", 32'(got.lword), 32'(want.lword));
				check_field("delivered_length", 32'(got.delivered), 32'(want.delivered));
			end
		end
		in_took = arst_n && in_valid && in_ready;
		if (in_took) begin
			seen.command = command;
			seen.length_value = length_value;
			seen.link_up = link_up;
			seen.slot_index = slot_index;
			seen.receive_status = receive_status;
			due_results.push_back(predict_ring(seen));
			accepted_cnt++;
		end
		cfg_took = arst_n && cfg_valid && cfg_ready;
		if (cfg_took)
			ring_en = cfg_data;
	end

	task automatic push_cmd(cmd_t c, logic [LEN_W-1:0] len, logic link,
			logic [SLOT_W-1:0] slot, logic [STAT_W-1:0] stat);
		ring_cmd_t w;
		w.command = c;
		w.length_value = len;
		w.link_up = link;
		w.slot_index = slot;
		w.receive_status = stat;
		cmd_backlog.push_back(w);
		queued_cnt++;
	endtask

	task automatic wait_idle();
		do @(negedge clk); while (accepted_cnt != queued_cnt || due_results.size() != 0);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_enable(logic v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(negedge clk); while (!cfg_took);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [STAT_W-1:0] rx_status_word();
		logic [STAT_W-1:0] s;
		s = $urandom;
		s[RX_OWN_BIT] = 1'b0;
		s[RX_ERR_BIT] = 1'b0;
		s[RX_FIRST_BIT] = 1'b1;
		s[RX_LAST_BIT] = 1'b1;
		case ($urandom_range(5))
			0: s[RX_LEN_MSB:RX_LEN_LSB] = LEN_W'($urandom_range(0, 3));
			1, 2: s[RX_LEN_MSB:RX_LEN_LSB] = LEN_W'($urandom_range(4, 1522));
			3: s[RX_LEN_MSB:RX_LEN_LSB] = '1;
			default: ;
		endcase
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(2))
				0: s[RX_ERR_BIT] = 1'b1;
				1: s[RX_FIRST_BIT] = 1'b0;
				default: s[RX_LAST_BIT] = 1'b0;
			endcase
		end
		return s;
	endfunction

	function automatic logic [LEN_W-1:0] rx_capacity();
		case ($urandom_range(3))
			0: return '1;
			1: return LEN_W'($urandom_range(0, 64));
			default: return LEN_W'($urandom);
		endcase
	endfunction

	task automatic gen_phase(gen_mode_t m, logic en, int n);
		int k;
		int pick;
		int cnt;
		logic [LEN_W-1:0] len;
		logic link;
		logic good;
		cnt = 0;
		for (int j = 0; j < RING_ENTRIES; j++)
			cnt += tx_owned[j];
		tx_out = cnt;
		tx_rel = tx_head - SLOT_W'(cnt);
		rx_wr = rx_head;
		k = 0;
		while (k < n) begin
			pick = $urandom_range(99);
			if (m == MODE_NOISE || pick < 12) begin
				push_cmd(cmd_t'($urandom_range(3)), LEN_W'($urandom), 1'($urandom_range(1)),
					SLOT_W'($urandom), $urandom);
				k++;
			end else if (m == MODE_RX || (m == MODE_MIX && pick < 55)) begin
				push_cmd(CMD_RX_WRITTEN, LEN_W'($urandom), 1'($urandom_range(1)), rx_wr,
					rx_status_word());
				push_cmd(CMD_RX_TAKE, rx_capacity(), 1'($urandom_range(1)), SLOT_W'($urandom),
					$urandom);
				rx_wr = rx_wr + 1'b1;
				k += 2;
			end else if ((m == MODE_FILL) ? (pick < 90) : (pick < 80 && tx_out < 100)) begin
				good = ($urandom_range(9) != 0);
				if (good)
					case ($urandom_range(3))
						0: len = LEN_W'(1);
						1: len = LEN_W'(BUFFER_BYTES);
						default: len = LEN_W'($urandom_range(1, BUFFER_BYTES));
					endcase
				else
					len = ($urandom_range(1)) ? '0 : LEN_W'($urandom_range(BUFFER_BYTES + 1, 16383));
				link = ($urandom_range(9) != 0);
				push_cmd(CMD_TX_SUBMIT, len, link, SLOT_W'($urandom), $urandom);
				if (en && good && link && tx_out < RING_ENTRIES)
					tx_out++;
				k++;
			end else begin
				if (tx_out > 0) begin
					push_cmd(CMD_TX_RELEASE, LEN_W'($urandom), 1'($urandom_range(1)), tx_rel,
						$urandom);
					tx_rel = tx_rel + 1'b1;
					tx_out--;
				end else begin
					push_cmd(CMD_TX_RELEASE, LEN_W'($urandom), 1'($urandom_range(1)),
						SLOT_W'($urandom), $urandom);
				end
				k++;
			end
		end
	endtask

	task automatic run_phase(gen_mode_t m, logic en, int n);
		wait_idle();
		write_enable(en);
		gen_phase(m, en, n);
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		write_enable(1'b0);
		// disabled ring
		push_cmd(CMD_TX_SUBMIT, 14'd100, 1'b1, 7'd0, 32'd0);
		push_cmd(CMD_RX_TAKE, 14'd100, 1'b0, 7'd0, 32'd0);
		push_cmd(CMD_TX_RELEASE, 14'd0, 1'b0, 7'd127, 32'd0);
		push_cmd(CMD_RX_WRITTEN, 14'd0, 1'b0, 7'd0, 32'h8000_0000);
		wait_idle();
		write_enable(1'b1);
		// submit argument checks
		push_cmd(CMD_TX_SUBMIT, 14'd0, 1'b1, 7'd0, 32'd0);
		push_cmd(CMD_TX_SUBMIT, 14'd2049, 1'b1, 7'd0, 32'd0);
		push_cmd(CMD_TX_SUBMIT, 14'h3fff, 1'b1, 7'd0, 32'd0);
		push_cmd(CMD_TX_SUBMIT, 14'd2048, 1'b0, 7'd0, 32'd0);
		push_cmd(CMD_TX_SUBMIT, 14'd2048, 1'b1, 7'd0, 32'd0);
		push_cmd(CMD_TX_SUBMIT, 14'd1, 1'b1, 7'd0, 32'd0);
		push_cmd(CMD_TX_RELEASE, 14'd0, 1'b0, 7'd0, 32'd0);
		push_cmd(CMD_TX_RELEASE, 14'd0, 1'b0, 7'd1, 32'd0);
		// receive frames: empty, good, short, error, no first, no last, clamp
		push_cmd(CMD_RX_TAKE, 14'h3fff, 1'b0, 7'd0, 32'd0);
		push_cmd(CMD_RX_WRITTEN, 14'd0, 1'b0, 7'd0, 32'h0040_0300);
		push_cmd(CMD_RX_TAKE, 14'h3fff, 1'b0, 7'd0, 32'd0);
		push_cmd(CMD_RX_WRITTEN, 14'd0, 1'b0, 7'd1, 32'h0003_0300);
		push_cmd(CMD_RX_TAKE, 14'h3fff, 1'b0, 7'd0, 32'd0);
		push_cmd(CMD_RX_WRITTEN, 14'd0, 1'b0, 7'd2, 32'h0040_8300);
		push_cmd(CMD_RX_TAKE, 14'h3fff, 1'b0, 7'd0, 32'd0);
		push_cmd(CMD_RX_WRITTEN, 14'd0, 1'b0, 7'd3, 32'h0040_0100);
		push_cmd(CMD_RX_TAKE, 14'h3fff, 1'b0, 7'd0, 32'd0);
		push_cmd(CMD_RX_WRITTEN, 14'd0, 1'b0, 7'd4, 32'h0040_0200);
		push_cmd(CMD_RX_TAKE, 14'h3fff, 1'b0, 7'd0, 32'd0);
		push_cmd(CMD_RX_WRITTEN, 14'd0, 1'b0, 7'd5, 32'h3fff_0300);
		push_cmd(CMD_RX_TAKE, 14'd10, 1'b0, 7'd0, 32'd0);
		push_cmd(CMD_RX_WRITTEN, 14'h3fff, 1'b1, 7'd127, 32'hffff_ffff);

		run_phase(MODE_RX, 1'b1, 300);
		run_phase(MODE_FILL, 1'b1, 200);
		run_phase(MODE_NOISE, 1'b0, 60);
		run_phase(MODE_MIX, 1'b1, 250);
		run_phase(MODE_RX, 1'b1, 220);
		wait_idle();

		if (err_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
